// ===== src/msb_bit_packer_with_patch_macros.svh =====
// Assertion macros for the MSB-first bit packer checker.
// Used by mbp_checker; expects clk and arst_n in scope.
`ifndef MSB_BIT_PACKER_WITH_PATCH_MACROS_SVH
`define MSB_BIT_PACKER_WITH_PATCH_MACROS_SVH

// Same-cycle implication under reset disable.
`define MBP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication under reset disable.
`define MBP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/mbp_pkg.sv =====
// Shared types and constants for the MSB-first bit packer.
// No dependencies; imported by every module of the block.
package mbp_pkg;

	localparam int MAX_BYTES      = 4096;
	localparam int MAX_FIELD_BITS = 32;
	localparam int IDX_W          = $clog2(MAX_BYTES);
	localparam int CNT_W          = $clog2(MAX_BYTES + 1);
	localparam int FIELD_W        = 32;
	localparam int SIZE_W         = 6;
	localparam int ANC_W          = 16;
	localparam int POS_W          = 16;
	localparam int POS_MAX        = 32767;
	localparam int S_TDATA_W      = 56;
	localparam int M_TDATA_W      = 48;
	localparam int Q_DEPTH        = 2;
	localparam int Q_PTR_W        = $clog2(Q_DEPTH);
	localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_BIT   = 2'd0,
		OP_FIELD = 2'd1,
		OP_PAD   = 2'd2,
		OP_PATCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_PATCH = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_PATCH,
		ST_END
	} state_t;

	// Classified command passed from front to back
	typedef struct packed {
		op_t                 op;
		logic [FIELD_W-1:0]  bits;     // bits to append, next bit at the top
		logic [SIZE_W-1:0]   nbits;    // number of bits to append
		logic                value;    // value forced at the anchor
		logic                anc_ok;   // anchor is not negative
		logic [IDX_W-1:0]    anc_idx;
		logic [2:0]          anc_bit;
	} cmd_t;

	typedef struct packed {
		kind_t               kind;
		logic [IDX_W-1:0]    byte_index;
		logic [7:0]          byte_value;
		logic [7:0]          color_bits;
		logic [POS_W-1:0]    bit_position;
		logic                overflow;
		logic                last;
	} result_t;

endpackage

// ===== src/mbp_front.sv =====
// Front end: accepts input items and classifies them into commands.
// Depends on mbp_pkg; feeds mbp_queue.
module mbp_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mbp_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          q_full,
	output logic                          q_push,
	output mbp_pkg::cmd_t                 q_cmd
);
	import mbp_pkg::*;

	logic [SIZE_W-1:0]  field_size;
	logic [FIELD_W-1:0] field_value;
	logic [ANC_W-1:0]   anchor;
	logic               bit_value;
	logic [SIZE_W-1:0]  size_c;
	op_t                op;

	// Unpack the payload
	assign op          = op_t'(s_tuser);
	assign bit_value   = s_tdata[0];
	assign field_size  = s_tdata[SIZE_W:1];
	assign field_value = s_tdata[SIZE_W+FIELD_W:SIZE_W+1];
	assign anchor      = s_tdata[SIZE_W+FIELD_W+ANC_W:SIZE_W+FIELD_W+1];

	// Clamp the field length
	assign size_c = (field_size > SIZE_W'(MAX_FIELD_BITS)) ? SIZE_W'(MAX_FIELD_BITS) : field_size;

	// Take an item whenever the queue has room
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Build the command: append data is left-aligned
	always_comb begin
		q_cmd         = '0;
		q_cmd.op      = op;
		q_cmd.value   = bit_value;
		q_cmd.anc_ok  = !anchor[ANC_W-1];
		q_cmd.anc_idx = anchor[IDX_W+2:3];
		q_cmd.anc_bit = anchor[2:0];
		unique case (op)
			OP_BIT: begin
				q_cmd.bits  = {bit_value, {(FIELD_W-1){1'b0}}};
				q_cmd.nbits = SIZE_W'(1);
			end
			OP_FIELD: begin
				q_cmd.bits  = field_value << (SIZE_W'(FIELD_W) - size_c);
				q_cmd.nbits = size_c;
			end
			OP_PAD, OP_PATCH: begin
				q_cmd.bits  = '0;
				q_cmd.nbits = '0;
			end
			default: begin
				q_cmd.bits  = '0;
				q_cmd.nbits = '0;
			end
		endcase
	end

endmodule

// ===== src/mbp_queue.sv =====
// Short command queue between the front and back ends.
// Depends on mbp_pkg for the command type and depth.
module mbp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbp_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output mbp_pkg::cmd_t head
);
	import mbp_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Hold command payloads
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/mbp_back.sv =====
// Back end: executes commands against the bit state and the byte store.
// Depends on mbp_pkg; owns the byte/color memory and the result register.
module mbp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  mbp_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output mbp_pkg::result_t res
);
	import mbp_pkg::*;

	// Bit position of the last written bit, saturated
	function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] cnt,
	                                            input logic [2:0] fill);
		logic [CNT_W+2:0] raw;
		raw = {cnt, fill};
		if (raw == '0) begin
			pos_of = '1;
		end else if (raw > (CNT_W+3)'(POS_MAX + 1)) begin
			pos_of = POS_W'(POS_MAX);
		end else begin
			pos_of = POS_W'(raw - 1'b1);
		end
	endfunction

	state_t             state_q, state_d;
	logic [7:0]         partial_q, partial_d;
	logic [7:0]         pcolor_q, pcolor_d;
	logic [2:0]         fill_q, fill_d;
	logic               color_q, color_d;
	logic [CNT_W-1:0]   stored_q, stored_d;
	logic               ovf_q, ovf_d;
	logic [FIELD_W-1:0] bits_q, bits_d;
	logic [SIZE_W-1:0]  rem_q, rem_d;
	logic [IDX_W-1:0]   pidx_q, pidx_d;
	logic [2:0]         pbit_q, pbit_d;
	logic               pval_q, pval_d;

	logic               out_valid_q;
	result_t            out_q;
	logic               emit_en;
	result_t            emit_res;
	logic               out_free;

	logic [15:0]        mem [MAX_BYTES];
	logic [15:0]        rd_q;
	logic               mem_we;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_addr;
	logic [15:0]        mem_wdata;

	logic [3:0]         room;
	logic [3:0]         take;
	logic [7:0]         top_mask;
	logic [7:0]         ins_data;
	logic [7:0]         ins_mask;
	logic [3:0]         fill_sum;
	logic               byte_done;
	logic               full;
	logic               append_go;
	logic               append_last;
	logic [CNT_W-1:0]   head_idx;
	logic [7:0]         head_mask;
	logic [7:0]         patch_mask;
	logic [7:0]         patched;

	// Slice of the next bits that fits into the partial byte
	assign room        = 4'd8 - {1'b0, fill_q};
	assign take        = ({2'b0, room} > rem_q) ? rem_q[3:0] : room;
	assign top_mask    = ~(8'hFF >> take);
	assign ins_data    = (bits_q[FIELD_W-1:FIELD_W-8] & top_mask) >> fill_q;
	assign ins_mask    = top_mask >> fill_q;
	assign fill_sum    = {1'b0, fill_q} + take;
	assign byte_done   = fill_sum[3];
	assign full        = (stored_q == CNT_W'(MAX_BYTES));
	assign out_free    = !out_valid_q || res_ready;
	assign append_go   = (byte_done && !full) ? out_free : 1'b1;
	assign append_last = (rem_q == {2'b0, take});

	// Anchor decode for the queue head
	assign head_idx    = {1'b0, q_head.anc_idx};
	assign head_mask   = 8'h80 >> q_head.anc_bit;
	assign patch_mask  = 8'h80 >> pbit_q;
	assign patched     = pval_q ? (rd_q[15:8] | patch_mask) : (rd_q[15:8] & ~patch_mask);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_head.op)
						OP_BIT, OP_FIELD: begin
							state_d = (q_head.nbits == '0) ? ST_END : ST_APPEND;
						end
						OP_PAD: begin
							state_d = (fill_q == '0) ? ST_END : ST_APPEND;
						end
						OP_PATCH: begin
							state_d = (q_head.anc_ok && head_idx < stored_q) ? ST_PATCH : ST_END;
						end
						default: state_d = ST_END;
					endcase
				end
			end
			ST_APPEND: begin
				if (append_go && append_last) begin
					state_d = ST_END;
				end
			end
			ST_PATCH: begin
				if (out_free) begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath, memory and result control
	always_comb begin
		partial_d = partial_q;
		pcolor_d  = pcolor_q;
		fill_d    = fill_q;
		color_d   = color_q;
		stored_d  = stored_q;
		ovf_d     = ovf_q;
		bits_d    = bits_q;
		rem_d     = rem_q;
		pidx_d    = pidx_q;
		pbit_d    = pbit_q;
		pval_d    = pval_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = pidx_q;
		mem_wdata = '0;
		emit_en   = 1'b0;
		emit_res  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					pidx_d = q_head.anc_idx;
					pbit_d = q_head.anc_bit;
					pval_d = q_head.value;
					unique case (q_head.op)
						OP_BIT, OP_FIELD: begin
							color_d = !color_q;
							bits_d  = q_head.bits;
							rem_d   = q_head.nbits;
						end
						OP_PAD: begin
							color_d = !color_q;
							bits_d  = '0;
							rem_d   = (fill_q == '0) ? '0 : SIZE_W'(4'd8 - {1'b0, fill_q});
						end
						OP_PATCH: begin
							// Patch the partial byte in place, or fetch a stored one
							if (q_head.anc_ok && head_idx == stored_q) begin
								partial_d = q_head.value ? (partial_q | head_mask)
								                         : (partial_q & ~head_mask);
							end else if (q_head.anc_ok && head_idx < stored_q) begin
								mem_re   = 1'b1;
								mem_addr = q_head.anc_idx;
							end
						end
						default: ;
					endcase
				end
			end
			ST_APPEND: begin
				if (append_go) begin
					bits_d = bits_q << take;
					rem_d  = rem_q - SIZE_W'(take);
					if (byte_done) begin
						partial_d = '0;
						pcolor_d  = '0;
						fill_d    = '0;
						if (full) begin
							ovf_d = 1'b1;
						end else begin
							stored_d              = stored_q + 1'b1;
							mem_we                = 1'b1;
							mem_addr              = stored_q[IDX_W-1:0];
							mem_wdata             = {partial_q | ins_data,
							                         color_q ? (pcolor_q | ins_mask) : pcolor_q};
							emit_en               = 1'b1;
							emit_res.kind         = KIND_BYTE;
							emit_res.byte_index   = stored_q[IDX_W-1:0];
							emit_res.byte_value   = partial_q | ins_data;
							emit_res.color_bits   = color_q ? (pcolor_q | ins_mask) : pcolor_q;
							emit_res.bit_position = pos_of(stored_q + 1'b1, 3'd0);
							emit_res.overflow     = ovf_q;
							emit_res.last         = 1'b0;
						end
					end else begin
						partial_d = partial_q | ins_data;
						pcolor_d  = color_q ? (pcolor_q | ins_mask) : pcolor_q;
						fill_d    = fill_sum[2:0];
					end
				end
			end
			ST_PATCH: begin
				if (out_free) begin
					mem_we                = 1'b1;
					mem_addr              = pidx_q;
					mem_wdata             = {patched, rd_q[7:0]};
					emit_en               = 1'b1;
					emit_res.kind         = KIND_PATCH;
					emit_res.byte_index   = pidx_q;
					emit_res.byte_value   = patched;
					emit_res.color_bits   = rd_q[7:0];
					emit_res.bit_position = pos_of(stored_q, fill_q);
					emit_res.overflow     = ovf_q;
					emit_res.last         = 1'b0;
				end
			end
			ST_END: begin
				if (out_free) begin
					emit_en               = 1'b1;
					emit_res.kind         = KIND_END;
					emit_res.bit_position = pos_of(stored_q, fill_q);
					emit_res.overflow     = ovf_q;
					emit_res.last         = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control and bit state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			partial_q   <= '0;
			pcolor_q    <= '0;
			fill_q      <= '0;
			color_q     <= 1'b0;
			stored_q    <= '0;
			ovf_q       <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			partial_q <= partial_d;
			pcolor_q  <= pcolor_d;
			fill_q    <= fill_d;
			color_q   <= color_d;
			stored_q  <= stored_d;
			ovf_q     <= ovf_d;
			rem_q     <= rem_d;
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		bits_q <= bits_d;
		pidx_q <= pidx_d;
		pbit_q <= pbit_d;
		pval_q <= pval_d;
		if (emit_en) begin
			out_q <= emit_res;
		end
	end

	// Single-port byte and color store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== src/msb_bit_packer_with_patch.sv =====
// MSB-first bit packer with patching. Input items (append bit, append field of
// up to 32 bits, pad to a byte, set one bit at an absolute anchor) enter a
// two-entry command queue and are executed one at a time by the back end.
// An append starts, fills each byte slice it touches in turn (up to five for
// a 32-bit field) and then gives the end-of-step result; a stored-byte patch
// reads the byte, writes it back and then gives its end result. The store
// is one single-port memory of 4096 bytes with colors, so each cycle writes
// at most one completed byte. Every item ends with one result flagged tlast;
// completed and patched bytes come before it. Bytes past the store's end are
// dropped and set the sticky overflow flag. Output stalls do not block input
// while the queue has room.
module msb_bit_packer_with_patch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// bit_value[0], field_size[6:1], field_value[38:7], anchor[54:39], zero[55]
	input  logic [mbp_pkg::S_TDATA_W-1:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// byte_index[11:0], byte_value[19:12], color_bits[27:20],
	// bit_position[43:28], overflow[44], zero[47:45]
	output logic [mbp_pkg::M_TDATA_W-1:0] m_tdata,
	// kind[1:0]
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);
	import mbp_pkg::*;

	logic    q_full;
	logic    q_push;
	cmd_t    q_cmd;
	logic    q_pop;
	logic    q_valid;
	cmd_t    q_head;
	result_t res;

	mbp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	mbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	mbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result item
	assign m_tdata = M_TDATA_W'({res.overflow, res.bit_position, res.color_bits,
	                             res.byte_value, res.byte_index});
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

// ===== src/mbp_checker.sv =====
// Port-level checks for the MSB-first bit packer, bound to the top level.
// Depends on msb_bit_packer_with_patch_macros.svh and mbp_pkg.
`include "msb_bit_packer_with_patch_macros.svh"

module mbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mbp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [1:0]                    m_tuser,
	input logic                          m_tlast
);
	import mbp_pkg::*;

	// A stalled result holds
	`MBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// Only the end-of-step result carries tlast
	`MBP_ASSERT_NOW(a_last_kind, m_tvalid, m_tlast == (m_tuser == KIND_END), "tlast does not match end-of-step kind")

	// End-of-step result has no byte payload
	`MBP_ASSERT_NOW(a_end_zero, m_tvalid && m_tuser == KIND_END, m_tdata[27:0] == '0, "end-of-step result carries byte data")

	// Unused kind code never appears
	`MBP_ASSERT_NOW(a_kind_legal, m_tvalid, m_tuser == KIND_BYTE || m_tuser == KIND_PATCH || m_tuser == KIND_END, "illegal result kind")

endmodule

bind msb_bit_packer_with_patch mbp_checker u_mbp_checker (.*);
